// File: design/prs_pkg.sv
`default_nettype none
package prs_pkg;

    // geometry fixed by the field widths
    localparam int PAGE_W  = 6;
    localparam int FRAME_W = 4;
    localparam int FILL_W  = 5;
    localparam int VPAGES  = 64;
    localparam int MFRAMES = 16;
    localparam int GROUP_W = 3;
    localparam int CNT_W   = 32;
    localparam int SEED_W  = 16;
    localparam int CFG_IDX_W = 2;

    // replacement policies
    localparam logic [1:0] POL_FIFO   = 2'd0;
    localparam logic [1:0] POL_LRU    = 2'd1;
    localparam logic [1:0] POL_RANDOM = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd2;

    // command into the lru row
    typedef struct packed {
        logic               drop_en;
        logic [PAGE_W-1:0]  drop_page;
        logic               wr_en;
        logic [FRAME_W-1:0] wr_slot;
        logic [PAGE_W-1:0]  wr_page;
        logic [FRAME_W-1:0] wr_frame;
        logic [FILL_W-1:0]  fill;
        logic [FILL_W-1:0]  limit;
    } lru_cmd_t;

    // victim search result out of the lru row
    typedef struct packed {
        logic               found;
        logic [FRAME_W-1:0] frame;
    } lru_stat_t;

endpackage
`default_nettype wire

// File: design/prs_if.sv
`default_nettype none
interface prs_page_if;
    logic                       valid;
    logic                       ready;
    logic [prs_pkg::PAGE_W-1:0] page;
    modport source (output valid, output page, input ready);
    modport sink (input valid, input page, output ready);
endinterface

interface prs_result_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [prs_pkg::FRAME_W-1:0] frame;
    logic                        evicted_valid;
    logic [prs_pkg::PAGE_W-1:0]  evicted_page;
    logic [prs_pkg::PAGE_W-1:0]  out_block;
    logic                        in_block_valid;
    logic [prs_pkg::PAGE_W-1:0]  in_block;
    logic [prs_pkg::CNT_W-1:0]   ref_count;
    logic [prs_pkg::CNT_W-1:0]   fault_count;
    modport source (output valid, output hit, output frame, output evicted_valid,
        output evicted_page, output out_block, output in_block_valid,
        output in_block, output ref_count, output fault_count, input ready);
    modport sink (input valid, input hit, input frame, input evicted_valid,
        input evicted_page, input out_block, input in_block_valid,
        input in_block, input ref_count, input fault_count, output ready);
endinterface
`default_nettype wire

// File: design/prs_lru_cell.sv
`default_nettype none
module prs_lru_cell (
    input  wire logic                        clk,
    input  wire prs_pkg::lru_cmd_t           cmd,
    input  wire logic [prs_pkg::FRAME_W-1:0] idx,
    input  wire logic [prs_pkg::PAGE_W-1:0]  nb_page,
    input  wire logic [prs_pkg::FRAME_W-1:0] nb_frame,
    input  wire logic                        drop_in,
    input  wire logic                        found_in,
    output logic                             drop_out,
    output logic                             found_out,
    output logic                             sel,
    output logic [prs_pkg::PAGE_W-1:0]       page,
    output logic [prs_pkg::FRAME_W-1:0]      frame
);
    logic [prs_pkg::PAGE_W-1:0]  page_reg,  page_next;
    logic [prs_pkg::FRAME_W-1:0] frame_reg, frame_next;
    logic                        live;
    logic                        has_next;
    logic                        cand;

    // slot holds a resident page when below the fill count
    assign live     = {1'b0, idx} < cmd.fill;
    assign has_next = ({1'b0, idx} + 5'd1) < cmd.fill;
    assign drop_out = drop_in | (live & (page_reg == cmd.drop_page));

    // first live slot whose frame lies below the limit
    assign cand      = live & ({1'b0, frame_reg} < cmd.limit);
    assign sel       = cand & ~found_in;
    assign found_out = found_in | cand;

    always_comb
    begin
        page_next  = page_reg;
        frame_next = frame_reg;
        if (cmd.drop_en && drop_out && has_next)
        begin
            page_next  = nb_page;
            frame_next = nb_frame;
        end
        else if (cmd.wr_en && cmd.wr_slot == idx)
        begin
            page_next  = cmd.wr_page;
            frame_next = cmd.wr_frame;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg  <= page_next;
        frame_reg <= frame_next;
    end

    assign page  = page_reg;
    assign frame = frame_reg;
endmodule
`default_nettype wire

// File: design/prs_lru_row.sv
`default_nettype none
module prs_lru_row (
    input  wire logic              clk,
    input  wire prs_pkg::lru_cmd_t cmd,
    output prs_pkg::lru_stat_t     stat
);
    localparam int N = prs_pkg::MFRAMES;

    logic [prs_pkg::PAGE_W-1:0]  pg  [N];
    logic [prs_pkg::FRAME_W-1:0] fr  [N];
    logic [N:0]                  drop_c;
    logic [N:0]                  found_c;
    logic [N-1:0]                sel;
    logic [prs_pkg::FRAME_W-1:0] vict;

    assign drop_c[0]  = 1'b0;
    assign found_c[0] = 1'b0;

    // row of cells, each shifting from its upper neighbour
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        prs_lru_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .idx       (prs_pkg::FRAME_W'(i)),
            .nb_page   (pg[(i + 1 < N) ? i + 1 : i]),
            .nb_frame  (fr[(i + 1 < N) ? i + 1 : i]),
            .drop_in   (drop_c[i]),
            .found_in  (found_c[i]),
            .drop_out  (drop_c[i+1]),
            .found_out (found_c[i+1]),
            .sel       (sel[i]),
            .page      (pg[i]),
            .frame     (fr[i])
        );
    end

    // one-hot pick of the victim frame
    always_comb
    begin
        vict = '0;
        for (int i = 0; i < N; i++)
            vict = vict | (sel[i] ? fr[i] : '0);
    end

    assign stat.found = found_c[N];
    assign stat.frame = vict;
endmodule
`default_nettype wire

// File: design/prs_mod_unit.sv
`default_nettype none
module prs_mod_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [prs_pkg::SEED_W-1:0]  dividend,
    input  wire logic [prs_pkg::FILL_W-1:0]  divisor,
    output logic                             done,
    output logic [prs_pkg::FRAME_W-1:0]      rem
);
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [3:0]                   cnt_reg,  cnt_next;
    logic [prs_pkg::SEED_W-1:0]   sh_reg,   sh_next;
    logic [prs_pkg::FILL_W-1:0]   rem_reg,  rem_next;
    logic [prs_pkg::FILL_W:0]     trial;

    // one remainder bit a cycle, restoring
    assign trial = {rem_reg, sh_reg[prs_pkg::SEED_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            sh_next   = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
                rem_next = prs_pkg::FILL_W'(trial - {1'b0, divisor});
            else
                rem_next = prs_pkg::FILL_W'(trial);
            sh_next  = {sh_reg[prs_pkg::SEED_W-2:0], 1'b0};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg[prs_pkg::FRAME_W-1:0];
endmodule
`default_nettype wire

// File: design/page_replacement_with_swap.sv
`default_nettype none
// Page replacement with swap. Takes one virtual page reference per transfer and
// returns one result per reference: hit/frame, the evicted page and the swap
// block it went to, the block the page came back from, and saturating counts of
// references and faults. Policy (FIFO, LRU, random) and frames in use are to be
// set through the write port only while idle; the block does not enforce this.
// Writing the seed reloads the LFSR. A sequencer works one reference at a time:
// a hit or a filling miss goes from lookup to the LRU update or placement; an
// eviction picks a victim (random: bit-serial modulo of the LFSR value), scans
// the swap bitmap for the lowest free block, 8 blocks a cycle. LRU order lives
// in a row of 16 cells that shift towards the head when a page leaves the list.
module page_replacement_with_swap (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    prs_page_if.sink                             req,
    prs_result_if.source                         rsp,
    input  wire logic                            cfg_we,
    input  wire logic [prs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [prs_pkg::SEED_W-1:0]      cfg_data
);
    localparam int PW = prs_pkg::PAGE_W;
    localparam int FW = prs_pkg::FRAME_W;
    localparam int CW = prs_pkg::FILL_W;
    localparam int NW = prs_pkg::CNT_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOOK  = 4'd1;
    localparam logic [3:0] S_MOD   = 4'd2;
    localparam logic [3:0] S_VICT  = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_EVICT = 4'd5;
    localparam logic [3:0] S_PLACE = 4'd6;
    localparam logic [3:0] S_HUPD  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]                state_reg, state_next;
    logic [1:0]                policy_reg, policy_next;
    logic [CW-1:0]             frames_reg, frames_next;
    logic [prs_pkg::SEED_W-1:0] lfsr_reg, lfsr_next, lfsr_step;
    logic [CW-1:0]             fill_reg, fill_next;
    logic [FW-1:0]             fifo_reg, fifo_next;
    logic [NW-1:0]             refs_reg, refs_next;
    logic [NW-1:0]             faults_reg, faults_next;
    logic [prs_pkg::VPAGES-1:0] present_reg, present_next;
    logic [prs_pkg::VPAGES-1:0] loaded_reg, loaded_next;
    logic [prs_pkg::VPAGES-1:0] used_reg, used_next;
    logic [prs_pkg::GROUP_W-1:0] grp_reg, grp_next;
    logic                      outv_reg, outv_next;

    // working payload
    logic [PW-1:0] page_reg, page_next;
    logic [FW-1:0] vf_reg, vf_next;
    logic [PW-1:0] vic_reg, vic_next;
    logic [PW-1:0] blk_reg, blk_next;
    logic          w_hit_reg, w_hit_next;
    logic          w_ev_reg, w_ev_next;
    logic          w_in_reg, w_in_next;
    logic [PW-1:0] w_inb_reg, w_inb_next;
    logic [PW-1:0] owner_reg [prs_pkg::MFRAMES];
    logic          owner_we;

    // result register
    logic          o_hit_reg;
    logic [FW-1:0] o_frame_reg;
    logic          o_ev_reg;
    logic [PW-1:0] o_evp_reg, o_blk_reg, o_inb_reg;
    logic          o_in_reg;
    logic [NW-1:0] o_refs_reg, o_faults_reg;
    logic          o_load;

    // page location memory
    logic [PW-1:0] loc_mem [prs_pkg::VPAGES];
    logic [PW-1:0] loc_rd_reg;
    logic          loc_we;
    logic [PW-1:0] loc_wa, loc_wd;

    logic [CW-1:0]  m;
    logic           accept;
    logic [7:0]     grp_bits;
    logic [2:0]     free_idx;
    logic           free_any;
    logic [CW-1:0]  fifo_v;
    logic           mod_start, mod_done;
    logic [FW-1:0]  mod_rem;
    prs_pkg::lru_cmd_t  lcmd;
    prs_pkg::lru_stat_t lstat;

    // usable frame count
    always_comb
    begin
        if (frames_reg == '0)
            m = CW'(1);
        else if (frames_reg > CW'(prs_pkg::MFRAMES))
            m = CW'(prs_pkg::MFRAMES);
        else
            m = frames_reg;
    end

    assign accept    = req.valid & req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign lfsr_step = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5],
                        lfsr_reg[prs_pkg::SEED_W-1:1]};
    assign fifo_v    = ({1'b0, fifo_reg} < m) ? {1'b0, fifo_reg} : '0;

    // lowest free block within the current group of eight
    assign grp_bits = used_reg[{grp_reg, 3'b000} +: 8];
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = 7; i >= 0; i--)
            if (!grp_bits[i])
            begin
                free_any = 1'b1;
                free_idx = 3'(i);
            end
    end

    prs_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (lfsr_step),
        .divisor  (m),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    prs_lru_row u_lru (
        .clk  (clk),
        .cmd  (lcmd),
        .stat (lstat)
    );

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        policy_next  = policy_reg;
        frames_next  = frames_reg;
        lfsr_next    = lfsr_reg;
        fill_next    = fill_reg;
        fifo_next    = fifo_reg;
        refs_next    = refs_reg;
        faults_next  = faults_reg;
        present_next = present_reg;
        loaded_next  = loaded_reg;
        used_next    = used_reg;
        grp_next     = grp_reg;
        outv_next    = outv_reg;
        page_next    = page_reg;
        vf_next      = vf_reg;
        vic_next     = vic_reg;
        blk_next     = blk_reg;
        w_hit_next   = w_hit_reg;
        w_ev_next    = w_ev_reg;
        w_in_next    = w_in_reg;
        w_inb_next   = w_inb_reg;
        owner_we     = 1'b0;
        loc_we       = 1'b0;
        loc_wa       = page_reg;
        loc_wd       = '0;
        mod_start    = 1'b0;
        o_load       = 1'b0;
        lcmd           = '0;
        lcmd.fill      = fill_reg;
        lcmd.limit     = m;
        lcmd.wr_slot   = FW'(fill_reg - CW'(1));
        lcmd.wr_page   = page_reg;
        lcmd.wr_frame  = vf_reg;
        lcmd.drop_page = page_reg;

        if (outv_reg && rsp.ready)
            outv_next = 1'b0;

        // configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                prs_pkg::CFG_POLICY: policy_next = cfg_data[1:0];
                prs_pkg::CFG_FRAMES: frames_next = cfg_data[CW-1:0];
                prs_pkg::CFG_SEED:
                    lfsr_next = (cfg_data == '0) ? prs_pkg::SEED_W'(1) : cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    page_next  = req.page;
                    refs_next  = (refs_reg == '1) ? refs_reg : refs_reg + NW'(1);
                    w_hit_next = 1'b0;
                    w_ev_next  = 1'b0;
                    w_in_next  = 1'b0;
                    w_inb_next = '0;
                    vic_next   = '0;
                    blk_next   = '0;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (present_reg[page_reg])
                begin
                    w_hit_next   = 1'b1;
                    vf_next      = loc_rd_reg[FW-1:0];
                    lcmd.drop_en = 1'b1;
                    state_next   = S_HUPD;
                end
                else
                begin
                    faults_next = (faults_reg == '1) ? faults_reg : faults_reg + NW'(1);
                    if (loaded_reg[page_reg])
                    begin
                        w_in_next  = 1'b1;
                        w_inb_next = loc_rd_reg;
                    end
                    if (fill_reg < m)
                    begin
                        vf_next   = fill_reg[FW-1:0];
                        fill_next = fill_reg + CW'(1);
                        if (loaded_reg[page_reg])
                            used_next[loc_rd_reg] = 1'b0;
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        priority case (policy_reg)
                            prs_pkg::POL_LRU:
                            begin
                                vf_next    = lstat.found ? lstat.frame : '0;
                                state_next = S_VICT;
                            end
                            prs_pkg::POL_RANDOM:
                            begin
                                lfsr_next  = lfsr_step;
                                mod_start  = 1'b1;
                                state_next = S_MOD;
                            end
                            default:
                            begin
                                vf_next    = fifo_v[FW-1:0];
                                fifo_next  = (fifo_v + CW'(1) == m) ? '0
                                           : FW'(fifo_v + CW'(1));
                                state_next = S_VICT;
                            end
                        endcase
                    end
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    vf_next    = mod_rem;
                    state_next = S_VICT;
                end
            end
            S_VICT:
            begin
                vic_next   = owner_reg[vf_reg];
                grp_next   = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (free_any)
                begin
                    blk_next   = {grp_reg, free_idx};
                    state_next = S_EVICT;
                end
                else if (grp_reg == '1)
                begin
                    blk_next   = '0;
                    state_next = S_EVICT;
                end
                else
                    grp_next = grp_reg + 3'd1;
            end
            S_EVICT:
            begin
                used_next[blk_reg] = 1'b1;
                if (w_in_reg)
                    used_next[w_inb_reg] = 1'b0;
                loc_we       = 1'b1;
                loc_wa       = vic_reg;
                loc_wd       = blk_reg;
                present_next[vic_reg] = 1'b0;
                w_ev_next    = 1'b1;
                lcmd.drop_en   = 1'b1;
                lcmd.drop_page = vic_reg;
                state_next   = S_PLACE;
            end
            S_PLACE:
            begin
                owner_we     = 1'b1;
                lcmd.wr_en   = 1'b1;
                loc_we       = 1'b1;
                loc_wd       = PW'(vf_reg);
                present_next[page_reg] = 1'b1;
                loaded_next[page_reg]  = 1'b1;
                state_next   = S_DONE;
            end
            S_HUPD:
            begin
                lcmd.wr_en = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!outv_reg)
                begin
                    o_load     = 1'b1;
                    outv_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            policy_reg  <= prs_pkg::POL_FIFO;
            frames_reg  <= CW'(prs_pkg::MFRAMES);
            lfsr_reg    <= prs_pkg::SEED_W'(1);
            fill_reg    <= '0;
            fifo_reg    <= '0;
            refs_reg    <= '0;
            faults_reg  <= '0;
            present_reg <= '0;
            loaded_reg  <= '0;
            used_reg    <= '0;
            grp_reg     <= '0;
            outv_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            policy_reg  <= policy_next;
            frames_reg  <= frames_next;
            lfsr_reg    <= lfsr_next;
            fill_reg    <= fill_next;
            fifo_reg    <= fifo_next;
            refs_reg    <= refs_next;
            faults_reg  <= faults_next;
            present_reg <= present_next;
            loaded_reg  <= loaded_next;
            used_reg    <= used_next;
            grp_reg     <= grp_next;
            outv_reg    <= outv_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        page_reg  <= page_next;
        vf_reg    <= vf_next;
        vic_reg   <= vic_next;
        blk_reg   <= blk_next;
        w_hit_reg <= w_hit_next;
        w_ev_reg  <= w_ev_next;
        w_in_reg  <= w_in_next;
        w_inb_reg <= w_inb_next;
        if (owner_we)
            owner_reg[vf_reg] <= page_reg;
        if (o_load)
        begin
            o_hit_reg    <= w_hit_reg;
            o_frame_reg  <= vf_reg;
            o_ev_reg     <= w_ev_reg;
            o_evp_reg    <= w_ev_reg ? vic_reg : '0;
            o_blk_reg    <= w_ev_reg ? blk_reg : '0;
            o_in_reg     <= w_in_reg;
            o_inb_reg    <= w_inb_reg;
            o_refs_reg   <= refs_reg;
            o_faults_reg <= faults_reg;
        end
    end

    // location memory, registered read at the incoming page
    always_ff @(posedge clk)
    begin
        if (loc_we)
            loc_mem[loc_wa] <= loc_wd;
        loc_rd_reg <= loc_mem[req.page];
    end

    assign rsp.valid          = outv_reg;
    assign rsp.hit            = o_hit_reg;
    assign rsp.frame          = o_frame_reg;
    assign rsp.evicted_valid  = o_ev_reg;
    assign rsp.evicted_page   = o_evp_reg;
    assign rsp.out_block      = o_blk_reg;
    assign rsp.in_block_valid = o_in_reg;
    assign rsp.in_block       = o_inb_reg;
    assign rsp.ref_count      = o_refs_reg;
    assign rsp.fault_count    = o_faults_reg;
endmodule
`default_nettype wire
